FILE: rtl/sas_pkg.sv
// shared constants for the sdf anti-aliased shape shader
// register map, shape codes, field widths and parameter defaults; no dependencies
package sas_pkg;

    localparam int P_W            = 18;   // shape register width, signed QxF
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 18;
    localparam int T_BITS         = 16;   // line parameter fraction bits
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int IN_DATA_W      = 80;
    localparam int OUT_DATA_W     = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_P0    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_P1    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_P2    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_P3    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_P4    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_P5    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_P6    = 3'd7;

    localparam logic [1:0] SHAPE_RRECT = 2'd0;
    localparam logic [1:0] SHAPE_RING  = 2'd1;
    localparam logic [1:0] SHAPE_BAND  = 2'd2;
    localparam logic [1:0] SHAPE_LINE  = 2'd3;

endpackage

FILE: rtl/sdf_antialias_shape_shader.sv
// MW + T_BITS + 20 register stages, MW = max(COORD_BITS+FRAC_BITS, 18); 54 at defaults
// throughput: one pixel per clock while the output is not stalled; the 16 divide stages of the
// line parameter and the MW+3 square root stages are each one restoring step per register stage
// a stalled output holds the whole pipeline; nothing is dropped or repeated
// reset (aresetn low, synchronous) clears all valid bits and the shape registers to zero
// depends on sas_pkg
module sdf_antialias_shape_shader #(
    parameter int COORD_BITS = sas_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sas_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_x, pixel_y, paint_rgb, dest_blue, dest_green, dest_red, dest_alpha
    input  logic [sas_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_blue, out_green, out_red, out_alpha
    output logic [sas_pkg::OUT_DATA_W-1:0]    m_tdata,
    // written
    output logic                              m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [sas_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sas_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int P_W   = sas_pkg::P_W;
    localparam int TB    = sas_pkg::T_BITS;
    localparam int CF    = COORD_BITS + FRAC_BITS;
    localparam int MW    = (CF > P_W) ? CF : P_W;
    localparam int D_W   = MW + 3;
    localparam int S_W   = 2 * D_W;
    localparam int R_W   = D_W;
    localparam int DW2   = R_W + 3;
    localparam int BT_W  = P_W + TB + 1;

    localparam int S_IN   = 0;
    localparam int S_OFS  = 1;
    localparam int S_ABS  = 2;
    localparam int S_Q    = 3;
    localparam int S_SQ   = 4;
    localparam int S_DIV0 = 5;
    localparam int S_T    = S_DIV0 + TB;
    localparam int S_BT   = S_T + 1;
    localparam int S_RND  = S_T + 2;
    localparam int S_DX   = S_T + 3;
    localparam int S_DSQ  = S_T + 4;
    localparam int S_SUM  = S_T + 5;
    localparam int S_SQR0 = S_T + 6;
    localparam int S_ROOT = S_SQR0 + R_W;
    localparam int S_DB   = S_ROOT + 1;
    localparam int S_DF   = S_ROOT + 2;
    localparam int S_COV  = S_ROOT + 3;
    localparam int S_MUL  = S_ROOT + 4;
    localparam int S_OUT  = S_ROOT + 5;
    localparam int NST    = S_OUT + 1;

    typedef struct packed {
        logic        [CF-1:0]   x;
        logic        [CF-1:0]   y;
        logic        [23:0]     paint;
        logic        [7:0]      db;
        logic        [7:0]      dg;
        logic        [7:0]      dr;
        logic        [7:0]      da;
        logic signed [D_W-1:0]  px;
        logic signed [D_W-1:0]  py;
        logic signed [D_W-1:0]  bl;
        logic signed [D_W-1:0]  br;
        logic signed [D_W-1:0]  bandm;
        logic signed [D_W-1:0]  ax;
        logic signed [D_W-1:0]  ay;
        logic signed [S_W:0]    mx;
        logic signed [S_W:0]    my;
        logic signed [D_W-1:0]  qx;
        logic signed [D_W-1:0]  qy;
        logic signed [S_W:0]    dot;
        logic        [S_W-1:0]  oxx;
        logic        [S_W-1:0]  oyy;
        logic signed [D_W-1:0]  mq;
        logic                   t_zero;
        logic                   t_one;
        logic        [S_W:0]    rem;
        logic        [TB-1:0]   q;
        logic        [TB:0]     t;
        logic        [BT_W-1:0] bxt;
        logic        [BT_W-1:0] byt;
        logic signed [D_W-1:0]  rx;
        logic signed [D_W-1:0]  ry;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic        [S_W-1:0]  dxx;
        logic        [S_W-1:0]  dyy;
        logic        [S_W-1:0]  rad;
        logic        [R_W+1:0]  srem;
        logic        [R_W-1:0]  root;
        logic        [R_W:0]    root_r;
        logic signed [DW2-1:0]  d;
        logic                   wr;
        logic        [8:0]      cov;
        logic signed [18:0]     pb;
        logic signed [18:0]     pg;
        logic signed [18:0]     pr;
    } pix_t;

    // shape registers and values derived from them
    logic        [1:0]     shape_reg;
    logic signed [P_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [P_W:0]   bx_reg, by_reg;
    logic signed [D_W-1:0] hw_reg, hh_reg;
    logic        [S_W-1:0] bxsq_reg, bysq_reg, len2_reg;
    logic        [P_W-1:0] bxa, bya;
    logic                  is_line;

    pix_t st_reg  [NST];
    pix_t st_next [NST];
    logic vld_reg [NST];
    logic ce;

    assign ce       = !vld_reg[NST-1] || m_tready;
    assign s_tready = ce;
    assign is_line  = (shape_reg == sas_pkg::SHAPE_LINE);
    assign bxa      = (bx_reg < 0) ? P_W'(-bx_reg) : P_W'(bx_reg);
    assign bya      = (by_reg < 0) ? P_W'(-by_reg) : P_W'(by_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= '0;
            p0_reg <= '0; p1_reg <= '0; p2_reg <= '0; p3_reg <= '0;
            p4_reg <= '0; p5_reg <= '0; p6_reg <= '0;
            bx_reg <= '0; by_reg <= '0; hw_reg <= '0; hh_reg <= '0;
            bxsq_reg <= '0; bysq_reg <= '0; len2_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    sas_pkg::REG_SHAPE: shape_reg <= cfg_wdata[1:0];
                    sas_pkg::REG_P0:    p0_reg <= cfg_wdata;
                    sas_pkg::REG_P1:    p1_reg <= cfg_wdata;
                    sas_pkg::REG_P2:    p2_reg <= cfg_wdata;
                    sas_pkg::REG_P3:    p3_reg <= cfg_wdata;
                    sas_pkg::REG_P4:    p4_reg <= cfg_wdata;
                    sas_pkg::REG_P5:    p5_reg <= cfg_wdata;
                    sas_pkg::REG_P6:    p6_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            bx_reg   <= (P_W+1)'(p2_reg) - (P_W+1)'(p0_reg);
            by_reg   <= (P_W+1)'(p3_reg) - (P_W+1)'(p1_reg);
            hw_reg   <= D_W'(p2_reg) - D_W'(p4_reg);
            hh_reg   <= D_W'(p3_reg) - D_W'(p4_reg);
            bxsq_reg <= $unsigned(S_W'(bx_reg) * S_W'(bx_reg));
            bysq_reg <= $unsigned(S_W'(by_reg) * S_W'(by_reg));
            len2_reg <= bxsq_reg + bysq_reg;
        end
    end

    // input word, pixel centre at (x + 0.5, y + 0.5)
    always_comb begin
        logic [COORD_BITS-1:0] xc, yc;
        xc = COORD_BITS'({16'b0, s_tdata[11:0]});
        yc = COORD_BITS'({16'b0, s_tdata[23:12]});
        st_next[S_IN]       = st_reg[S_IN];
        st_next[S_IN].x     = {xc, 1'b1, (FRAC_BITS-1)'(0)};
        st_next[S_IN].y     = {yc, 1'b1, (FRAC_BITS-1)'(0)};
        st_next[S_IN].paint = s_tdata[47:24];
        st_next[S_IN].db    = s_tdata[55:48];
        st_next[S_IN].dg    = s_tdata[63:56];
        st_next[S_IN].dr    = s_tdata[71:64];
        st_next[S_IN].da    = s_tdata[79:72];
    end

    always_comb begin
        pix_t c;
        logic signed [D_W-1:0] xs, ys;
        c  = st_reg[S_OFS-1];
        xs = D_W'($signed({1'b0, c.x}));
        ys = D_W'($signed({1'b0, c.y}));
        st_next[S_OFS]    = c;
        st_next[S_OFS].px = xs - D_W'(p0_reg);
        st_next[S_OFS].py = ys - D_W'(p1_reg);
        st_next[S_OFS].bl = D_W'(p5_reg) - xs;
        st_next[S_OFS].br = xs - D_W'(p6_reg);
    end

    always_comb begin
        pix_t c;
        c = st_reg[S_ABS-1];
        st_next[S_ABS]       = c;
        st_next[S_ABS].ax    = (c.px < 0) ? -c.px : c.px;
        st_next[S_ABS].ay    = (c.py < 0) ? -c.py : c.py;
        st_next[S_ABS].mx    = (S_W+1)'(c.px) * (S_W+1)'(bx_reg);
        st_next[S_ABS].my    = (S_W+1)'(c.py) * (S_W+1)'(by_reg);
        st_next[S_ABS].bandm = (c.bl > c.br) ? c.bl : c.br;
    end

    always_comb begin
        pix_t c;
        c = st_reg[S_Q-1];
        st_next[S_Q]     = c;
        st_next[S_Q].qx  = c.ax - hw_reg;
        st_next[S_Q].qy  = c.ay - hh_reg;
        st_next[S_Q].dot = c.mx + c.my;
    end

    always_comb begin
        pix_t c;
        logic signed [D_W-1:0] ox, oy, mqm;
        c   = st_reg[S_SQ-1];
        ox  = (c.qx > 0) ? c.qx : '0;
        oy  = (c.qy > 0) ? c.qy : '0;
        mqm = (c.qx > c.qy) ? c.qx : c.qy;
        st_next[S_SQ]        = c;
        st_next[S_SQ].oxx    = $unsigned(S_W'(ox) * S_W'(ox));
        st_next[S_SQ].oyy    = $unsigned(S_W'(oy) * S_W'(oy));
        st_next[S_SQ].mq     = (mqm < 0) ? mqm : '0;
        st_next[S_SQ].t_zero = (len2_reg == '0) || (c.dot <= 0);
        st_next[S_SQ].t_one  = (c.dot >= $signed({1'b0, len2_reg}));
        st_next[S_SQ].rem    = $unsigned(c.dot);
        st_next[S_SQ].q      = '0;
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < TB; k++) begin : g_div
        always_comb begin
            pix_t c;
            logic [S_W:0] r2;
            c  = st_reg[S_DIV0+k-1];
            r2 = {c.rem[S_W-1:0], 1'b0};
            st_next[S_DIV0+k] = c;
            if (r2 >= {1'b0, len2_reg}) begin
                st_next[S_DIV0+k].rem = r2 - {1'b0, len2_reg};
                st_next[S_DIV0+k].q   = {c.q[TB-2:0], 1'b1};
            end else begin
                st_next[S_DIV0+k].rem = r2;
                st_next[S_DIV0+k].q   = {c.q[TB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        pix_t c;
        c = st_reg[S_T-1];
        st_next[S_T] = c;
        if (c.t_zero) begin
            st_next[S_T].t = '0;
        end else if (c.t_one) begin
            st_next[S_T].t = {1'b1, TB'(0)};
        end else begin
            st_next[S_T].t = {1'b0, c.q};
        end
    end

    always_comb begin
        pix_t c;
        c = st_reg[S_BT-1];
        st_next[S_BT]     = c;
        st_next[S_BT].bxt = BT_W'(bxa) * BT_W'(c.t);
        st_next[S_BT].byt = BT_W'(bya) * BT_W'(c.t);
    end

    // b * t back to QF, rounded half away from zero
    always_comb begin
        pix_t c;
        logic [P_W:0]          magx, magy;
        logic signed [D_W-1:0] sx, sy;
        c    = st_reg[S_RND-1];
        magx = (P_W+1)'((c.bxt + BT_W'(1 << (TB-1))) >> TB);
        magy = (P_W+1)'((c.byt + BT_W'(1 << (TB-1))) >> TB);
        sx   = D_W'($signed({1'b0, magx}));
        sy   = D_W'($signed({1'b0, magy}));
        st_next[S_RND]    = c;
        st_next[S_RND].rx = (bx_reg < 0) ? -sx : sx;
        st_next[S_RND].ry = (by_reg < 0) ? -sy : sy;
    end

    always_comb begin
        pix_t c;
        c = st_reg[S_DX-1];
        st_next[S_DX]    = c;
        st_next[S_DX].dx = c.px - c.rx;
        st_next[S_DX].dy = c.py - c.ry;
    end

    always_comb begin
        pix_t c;
        c = st_reg[S_DSQ-1];
        st_next[S_DSQ]     = c;
        st_next[S_DSQ].dxx = $unsigned(S_W'(c.dx) * S_W'(c.dx));
        st_next[S_DSQ].dyy = $unsigned(S_W'(c.dy) * S_W'(c.dy));
    end

    always_comb begin
        pix_t c;
        c = st_reg[S_SUM-1];
        st_next[S_SUM]      = c;
        st_next[S_SUM].rad  = is_line ? (c.dxx + c.dyy) : (c.oxx + c.oyy);
        st_next[S_SUM].srem = '0;
        st_next[S_SUM].root = '0;
    end

    // digit by digit square root, one root bit per stage
    for (genvar k = 0; k < R_W; k++) begin : g_sqrt
        always_comb begin
            pix_t c;
            logic [R_W+3:0] rem4, trial;
            c     = st_reg[S_SQR0+k-1];
            rem4  = {c.srem, c.rad[S_W-1 -: 2]};
            trial = {2'b00, c.root, 2'b01};
            st_next[S_SQR0+k]     = c;
            st_next[S_SQR0+k].rad = {c.rad[S_W-3:0], 2'b00};
            if (rem4 >= trial) begin
                st_next[S_SQR0+k].srem = (R_W+2)'(rem4 - trial);
                st_next[S_SQR0+k].root = {c.root[R_W-2:0], 1'b1};
            end else begin
                st_next[S_SQR0+k].srem = (R_W+2)'(rem4);
                st_next[S_SQR0+k].root = {c.root[R_W-2:0], 1'b0};
            end
        end
    end

    // round to nearest: remainder above root means the next integer is closer
    always_comb begin
        pix_t c;
        c = st_reg[S_ROOT-1];
        st_next[S_ROOT]        = c;
        st_next[S_ROOT].root_r = {1'b0, c.root}
                               + (R_W+1)'(c.srem > (R_W+2)'(c.root));
    end

    always_comb begin
        pix_t c;
        logic signed [DW2-1:0] base;
        c    = st_reg[S_DB-1];
        base = DW2'($signed({1'b0, c.root_r})) - DW2'(p4_reg);
        st_next[S_DB]   = c;
        st_next[S_DB].d = is_line ? base : (base + DW2'(c.mq));
    end

    always_comb begin
        pix_t c;
        logic signed [DW2-1:0] e, b;
        c = st_reg[S_DF-1];
        e = -(c.d + DW2'(p5_reg));
        b = DW2'(c.bandm);
        st_next[S_DF] = c;
        unique case (shape_reg)
            sas_pkg::SHAPE_RING: st_next[S_DF].d = (e > c.d) ? e : c.d;
            sas_pkg::SHAPE_BAND: st_next[S_DF].d = (b > c.d) ? b : c.d;
            default:             st_next[S_DF].d = c.d;
        endcase
    end

    always_comb begin
        pix_t c;
        logic signed [DW2-1:0] a, ac;
        c  = st_reg[S_COV-1];
        a  = DW2'(1 << (FRAC_BITS-1)) - c.d;
        ac = (a > DW2'(1 << FRAC_BITS)) ? DW2'(1 << FRAC_BITS) : a;
        st_next[S_COV]     = c;
        st_next[S_COV].wr  = (a > 0);
        st_next[S_COV].cov = (a > 0) ? (9'(ac) << (8 - FRAC_BITS)) : '0;
    end

    always_comb begin
        pix_t c;
        logic signed [8:0] fb, fg, fr;
        logic signed [9:0] cv;
        c  = st_reg[S_MUL-1];
        fb = $signed({1'b0, c.paint[23:16]}) - $signed({1'b0, c.db});
        fg = $signed({1'b0, c.paint[15:8]}) - $signed({1'b0, c.dg});
        fr = $signed({1'b0, c.paint[7:0]}) - $signed({1'b0, c.dr});
        cv = $signed({1'b0, c.cov});
        st_next[S_MUL]    = c;
        st_next[S_MUL].pb = 19'(fb) * 19'(cv);
        st_next[S_MUL].pg = 19'(fg) * 19'(cv);
        st_next[S_MUL].pr = 19'(fr) * 19'(cv);
    end

    always_comb begin
        pix_t c;
        logic signed [18:0] nb, ng, nr;
        c  = st_reg[S_OUT-1];
        nb = $signed({3'b000, c.db, 8'd128}) + c.pb;
        ng = $signed({3'b000, c.dg, 8'd128}) + c.pg;
        nr = $signed({3'b000, c.dr, 8'd128}) + c.pr;
        st_next[S_OUT] = c;
        if (c.wr) begin
            st_next[S_OUT].db = nb[15:8];
            st_next[S_OUT].dg = ng[15:8];
            st_next[S_OUT].dr = nr[15:8];
            st_next[S_OUT].da = 8'hFF;
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_pipe
        always_ff @(posedge aclk) begin
            if (ce) begin
                st_reg[i] <= st_next[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ce) begin
                if (i == 0) begin
                    vld_reg[i] <= s_tvalid;
                end else begin
                    vld_reg[i] <= vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {st_reg[NST-1].da, st_reg[NST-1].dr, st_reg[NST-1].dg, st_reg[NST-1].db};
    assign m_tuser  = st_reg[NST-1].wr;

endmodule

FILE: rtl/sas_checker.sv
// port-level checks for the sdf anti-aliased shape shader, bound to the top level
// depends on sas_pkg
module sas_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sas_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // a held word keeps its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_alpha_written: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:24] == 8'hFF)
        else $error("written pixel without full alpha");

    // the pipeline moves as one, so input stalls exactly with the output
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind sdf_antialias_shape_shader sas_checker u_sas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
